>>> src/swmm_pkg.sv
// Shared types, constants and the window reduction for the square window min/max filter.
// No dependencies; every other file of the block but swmm_ram uses it by scoped names.
`default_nettype none

package swmm_pkg;

   // Storage limits
   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_RADIUS  = 7;
   localparam int TAPS        = 2 * MAX_RADIUS;      // stored rows behind the current one
   localparam int LANES       = TAPS + 1;            // window side at the largest radius
   localparam int TREE_N      = 16;                  // reduction tree leaves, >= LANES

   // Field widths
   localparam int PIX_W       = 8;
   localparam int DIM_W       = 12;                  // frame_width / frame_height
   localparam int RAD_W       = 3;
   localparam int COL_W       = $clog2(MAX_WIDTH);   // column counters
   localparam int ROW_W       = DIM_W + 1;           // input row counter runs past height
   localparam int CSR_IDX_W   = 2;
   localparam int ROW_WORD_W  = TAPS * PIX_W;        // one line store word: a column of rows

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_WINDOW_RADIUS = 2'd2,
      CSR_FILTER_MODE   = 2'd3
   } csr_index_type;

   // Effective configuration (already clamped)
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [RAD_W-1:0] radius;
      logic             mode;     // 0 minimum, 1 maximum
   } cfg_type;

   // One classified word between the front and the back
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] col;      // line store address
      logic [LANES-1:0] vmask;    // rows of this column inside the clipped window
      logic [LANES-1:0] hmask;    // columns inside the clipped window (emit only)
      logic             emit;
      logic             last;
   } work_type;

   function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic mode);
      if (mode) begin
         return (a > b) ? a : b;
      end
      return (a < b) ? a : b;
   endfunction

   // Masked min/max over the lanes, four tree levels
   function automatic logic [PIX_W-1:0] window_reduce(
      input logic [LANES-1:0][PIX_W-1:0] vals,
      input logic [LANES-1:0]            mask,
      input logic                        mode);
      logic [TREE_N-1:0][PIX_W-1:0]   l0;
      logic [TREE_N/2-1:0][PIX_W-1:0] l1;
      logic [TREE_N/4-1:0][PIX_W-1:0] l2;
      logic [TREE_N/8-1:0][PIX_W-1:0] l3;
      logic [PIX_W-1:0]               neutral;
      neutral = mode ? '0 : '1;
      for (int i = 0; i < TREE_N; i++) begin
         l0[i] = neutral;
      end
      for (int i = 0; i < LANES; i++) begin
         if (mask[i]) begin
            l0[i] = vals[i];
         end
      end
      for (int i = 0; i < TREE_N/2; i++) begin
         l1[i] = pick(l0[2*i], l0[2*i+1], mode);
      end
      for (int i = 0; i < TREE_N/4; i++) begin
         l2[i] = pick(l1[2*i], l1[2*i+1], mode);
      end
      for (int i = 0; i < TREE_N/8; i++) begin
         l3[i] = pick(l2[2*i], l2[2*i+1], mode);
      end
      return pick(l3[0], l3[1], mode);
   endfunction

endpackage

`default_nettype wire

>>> src/swmm_req_if.sv
// Input channel of the min/max filter: valid/ready plus one pixel word.
// Depends on swmm_pkg for field widths.
`default_nettype none

interface swmm_req_if;
   logic                      valid;
   logic                      ready;
   logic [swmm_pkg::PIX_W-1:0] pixel_in;
   logic                      is_fill;

   modport source (output valid, output pixel_in, output is_fill, input ready);
   modport sink   (input valid, input pixel_in, input is_fill, output ready);
endinterface

`default_nettype wire

>>> src/swmm_rsp_if.sv
// Result channel of the min/max filter: valid/ready plus one filtered pixel word.
// Depends on swmm_pkg for field widths.
`default_nettype none

interface swmm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [swmm_pkg::PIX_W-1:0] pixel_out;
   logic                      frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

>>> src/square_window_min_max_filter_core.sv
// Square window grayscale min/max filter (erosion / dilation), top level.
// Depends on swmm_pkg, swmm_req_if, swmm_rsp_if, swmm_front, swmm_queue, swmm_back.
//
// Usage:
//  - req_port takes one pixel word per cycle while ready, in raster order; is_fill marks
//    flush words. Fill words sent before the frame is complete are taken and dropped.
//  - rsp_port gives the min (filter_mode 0) or max (filter_mode 1) over the square window
//    of side 2r+1, clipped at the frame borders; frame_last marks the last pixel.
//  - Output for pixel n follows input word n + r*W + r; after a frame, r*W + r fill words
//    flush the remaining results. Results pass the queue, column, window and output stages.
//  - Throughput is one word per cycle unless rsp_port stalls; the line store (a 2048-deep
//    RAM word holding a column of TAPS rows, read and rewritten each word) sets that rate.
//  - csr_* writes take effect at once; write them only while no results are pending.
//  - Reset restores the register defaults (640x480, r=2, minimum) and clears position
//    counters and pipeline control; the line store needs no clearing.
//  - When rsp_port stalls, the output register holds its word, the back pipeline stops and
//    a four-word queue keeps taking input until it fills, then req_port.ready drops.
`default_nettype none

module square_window_min_max_filter_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   swmm_req_if.sink                            req_port,
   swmm_rsp_if.source                          rsp_port,
   input  wire logic                           csr_write_enable,
   input  wire logic [swmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [swmm_pkg::DIM_W-1:0]     csr_write_data
);

   logic [swmm_pkg::DIM_W-1:0] frame_width_ff;
   logic [swmm_pkg::DIM_W-1:0] frame_height_ff;
   logic [swmm_pkg::RAD_W-1:0] window_radius_ff;
   logic                       filter_mode_ff;

   swmm_pkg::cfg_type          cfg;
   swmm_pkg::work_type         push_data;
   swmm_pkg::work_type         q_head;
   logic                       push;
   logic                       q_full;
   logic                       q_empty;
   logic                       q_pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= swmm_pkg::DIM_W'(640);
         frame_height_ff  <= swmm_pkg::DIM_W'(480);
         window_radius_ff <= swmm_pkg::RAD_W'(2);
         filter_mode_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (swmm_pkg::csr_index_type'(csr_index))
            swmm_pkg::CSR_FRAME_WIDTH:   frame_width_ff   <= csr_write_data;
            swmm_pkg::CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_write_data;
            swmm_pkg::CSR_WINDOW_RADIUS: window_radius_ff <= csr_write_data[swmm_pkg::RAD_W-1:0];
            swmm_pkg::CSR_FILTER_MODE:   filter_mode_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Clamp to the supported range
   always_comb begin
      if (frame_width_ff == '0) begin
         cfg.width = swmm_pkg::DIM_W'(1);
      end else if (frame_width_ff > swmm_pkg::DIM_W'(swmm_pkg::MAX_WIDTH)) begin
         cfg.width = swmm_pkg::DIM_W'(swmm_pkg::MAX_WIDTH);
      end else begin
         cfg.width = frame_width_ff;
      end
      cfg.height = (frame_height_ff == '0) ? swmm_pkg::DIM_W'(1) : frame_height_ff;
      cfg.radius = (window_radius_ff > swmm_pkg::RAD_W'(swmm_pkg::MAX_RADIUS)) ?
                   swmm_pkg::RAD_W'(swmm_pkg::MAX_RADIUS) : window_radius_ff;
      cfg.mode   = filter_mode_ff;
   end

   swmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_port.valid),
      .in_pixel   (req_port.pixel_in),
      .in_fill    (req_port.is_fill),
      .in_ready   (req_port.ready),
      .queue_full (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   swmm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   swmm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (cfg.mode),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_pixel (rsp_port.pixel_out),
      .out_last  (rsp_port.frame_last)
   );

endmodule

`default_nettype wire

>>> src/swmm_ram.sv
// Generic single-write, single-read RAM with registered read data (read before write).
// No dependencies.
`default_nettype none

module swmm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/swmm_front.sv
// Front of the filter: frame position counters, drop/flush classification and window masks.
// Depends on swmm_pkg; feeds swmm_queue.
`default_nettype none

module swmm_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire swmm_pkg::cfg_type          cfg,
   input  wire logic                       in_valid,
   input  wire logic [swmm_pkg::PIX_W-1:0] in_pixel,
   input  wire logic                       in_fill,
   output      logic                       in_ready,
   input  wire logic                       queue_full,
   output      logic                       push,
   output      swmm_pkg::work_type         push_data
);

   localparam int RR_W  = swmm_pkg::RAD_W + 1;
   localparam int RX_W  = swmm_pkg::ROW_W + 1;
   localparam int IDX_W = swmm_pkg::ROW_W + swmm_pkg::DIM_W;

   logic [swmm_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [swmm_pkg::ROW_W-1:0] in_row_ff, in_row_in;
   logic [swmm_pkg::COL_W-1:0] out_col_ff, out_col_in;
   logic [swmm_pkg::DIM_W-1:0] out_row_ff, out_row_in;

   logic                       accept;
   logic                       flushing;
   logic                       counted;
   logic                       started;
   logic                       out_last;
   logic [IDX_W-1:0]           lin_idx;
   logic [IDX_W-1:0]           lead;
   logic [swmm_pkg::DIM_W-1:0] col_inc;
   logic [swmm_pkg::DIM_W-1:0] ocol_inc;
   logic [swmm_pkg::DIM_W-1:0] hcenter;
   logic [RR_W-1:0]            two_r;
   logic [swmm_pkg::LANES-1:0] vmask;
   logic [swmm_pkg::LANES-1:0] hmask;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // Fill words before the frame is complete are dropped
   assign flushing = in_row_ff >= swmm_pkg::ROW_W'(cfg.height);
   assign counted  = accept && !(in_fill && !flushing);

   // Output starts once the input index reaches r*W + r (also when r exceeds W)
   assign lin_idx  = IDX_W'(in_row_ff) * IDX_W'(cfg.width) + IDX_W'(in_col_ff);
   assign lead     = IDX_W'(cfg.radius) * IDX_W'(cfg.width) + IDX_W'(cfg.radius);
   assign started  = lin_idx >= lead;
   assign out_last = started &&
                     (swmm_pkg::DIM_W'(out_col_ff) == cfg.width - 1'b1) &&
                     (out_row_ff == cfg.height - 1'b1);

   assign col_inc  = swmm_pkg::DIM_W'(in_col_ff) + 1'b1;
   assign ocol_inc = swmm_pkg::DIM_W'(out_col_ff) + 1'b1;
   assign hcenter  = swmm_pkg::DIM_W'(out_col_ff) + swmm_pkg::DIM_W'(cfg.radius);
   assign two_r    = {cfg.radius, 1'b0};

   // Vertical mask: tap k is row in_row-k; keep it inside the window and the frame
   always_comb begin
      for (int k = 0; k < swmm_pkg::LANES; k++) begin
         vmask[k] = (RR_W'(k) <= two_r) &&
                    (swmm_pkg::ROW_W'(k) <= in_row_ff) &&
                    (RX_W'(in_row_ff) < RX_W'(cfg.height) + RX_W'(k));
      end
   end

   // Horizontal mask: lane j holds column out_col+r-j of the output row
   always_comb begin
      for (int j = 0; j < swmm_pkg::LANES; j++) begin
         hmask[j] = (RR_W'(j) <= two_r) &&
                    (swmm_pkg::DIM_W'(j) <= hcenter) &&
                    (swmm_pkg::DIM_W'(j) + cfg.width - 1'b1 >= hcenter);
      end
   end

   // Counter next state
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (counted) begin
         if (col_inc >= cfg.width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = col_inc[swmm_pkg::COL_W-1:0];
         end
         if (started) begin
            if (out_last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (ocol_inc >= cfg.width) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = ocol_inc[swmm_pkg::COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Word to the back
   assign push            = counted;
   assign push_data.pix   = in_pixel;
   assign push_data.col   = in_col_ff;
   assign push_data.vmask = vmask;
   assign push_data.hmask = hmask;
   assign push_data.emit  = started;
   assign push_data.last  = out_last;

endmodule

`default_nettype wire

>>> src/swmm_queue.sv
// Short flop FIFO between the front and the back of the filter.
// Depends on swmm_pkg for the word type and depth.
`default_nettype none

module swmm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire swmm_pkg::work_type push_data,
   output      logic               full,
   input  wire logic               pop,
   output      swmm_pkg::work_type head,
   output      logic               empty
);

   swmm_pkg::work_type              slot_ff [swmm_pkg::QUEUE_DEPTH];
   logic [swmm_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [swmm_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [swmm_pkg::QPTR_W:0]       count_ff, count_in;

   assign full  = count_ff == (swmm_pkg::QPTR_W + 1)'(swmm_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> src/swmm_back.sv
// Back of the filter: line store, column min/max, horizontal window and output register.
// Depends on swmm_pkg and swmm_ram; fed by swmm_queue.
`default_nettype none

module swmm_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       mode,
   input  wire logic                       q_empty,
   input  wire swmm_pkg::work_type         q_head,
   output      logic                       q_pop,
   output      logic                       out_valid,
   input  wire logic                       out_ready,
   output      logic [swmm_pkg::PIX_W-1:0] out_pixel,
   output      logic                       out_last
);

   logic                                              en;
   logic [swmm_pkg::ROW_WORD_W-1:0]                   rd_word;
   logic [swmm_pkg::ROW_WORD_W-1:0]                   tap_word;
   logic [swmm_pkg::ROW_WORD_W-1:0]                   wr_word;
   logic                                              wr_en;
   logic [swmm_pkg::LANES-1:0][swmm_pkg::PIX_W-1:0]   column;
   logic [swmm_pkg::PIX_W-1:0]                        vert;
   logic                                              fwd_hit_in;

   // Column stage
   logic                                              b2_valid_ff;
   swmm_pkg::work_type                                b2_work_ff;
   logic                                              fwd_hit_ff;
   logic [swmm_pkg::ROW_WORD_W-1:0]                   fwd_word_ff;

   // Window stage
   logic                                              b3_valid_ff;
   logic                                              b3_emit_ff;
   logic                                              b3_last_ff;
   logic [swmm_pkg::LANES-1:0]                        b3_hmask_ff;
   logic [swmm_pkg::LANES-1:0][swmm_pkg::PIX_W-1:0]   hreg_ff;

   // Output register
   logic                                              rsp_valid_ff;
   logic [swmm_pkg::PIX_W-1:0]                        rsp_pixel_ff;
   logic                                              rsp_last_ff;

   // Whole pipeline moves when the output register is free
   assign en    = !rsp_valid_ff || out_ready;
   assign q_pop = en && !q_empty;

   // Line store: word at a column holds the previous TAPS rows, newest in slot 0
   swmm_ram #(
      .WIDTH (swmm_pkg::ROW_WORD_W),
      .DEPTH (swmm_pkg::MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b2_work_ff.col),
      .wr_data (wr_word),
      .rd_en   (q_pop),
      .rd_addr (q_head.col),
      .rd_data (rd_word)
   );

   // Forward a write that landed in the same cycle as the read
   assign tap_word   = fwd_hit_ff ? fwd_word_ff : rd_word;
   assign wr_word    = {tap_word[swmm_pkg::ROW_WORD_W-swmm_pkg::PIX_W-1:0], b2_work_ff.pix};
   assign wr_en      = en && b2_valid_ff;
   assign fwd_hit_in = b2_valid_ff && (b2_work_ff.col == q_head.col);

   // Column of the window: current pixel plus the stored rows
   always_comb begin
      column[0] = b2_work_ff.pix;
      for (int k = 1; k < swmm_pkg::LANES; k++) begin
         column[k] = tap_word[(k-1)*swmm_pkg::PIX_W +: swmm_pkg::PIX_W];
      end
   end

   assign vert = swmm_pkg::window_reduce(column, b2_work_ff.vmask, mode);

   // Stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         b3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b2_valid_ff  <= q_pop;
         fwd_hit_ff   <= fwd_hit_in;
         b3_valid_ff  <= b2_valid_ff;
         rsp_valid_ff <= b3_valid_ff && b3_emit_ff;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         b2_work_ff   <= q_head;
         fwd_word_ff  <= wr_word;
         b3_emit_ff   <= b2_work_ff.emit;
         b3_last_ff   <= b2_work_ff.last;
         b3_hmask_ff  <= b2_work_ff.hmask;
         rsp_pixel_ff <= swmm_pkg::window_reduce(hreg_ff, b3_hmask_ff, mode);
         rsp_last_ff  <= b3_last_ff;
      end
      // Column results of the last LANES words, newest in lane 0
      if (en && b2_valid_ff) begin
         hreg_ff[0] <= vert;
         for (int j = 1; j < swmm_pkg::LANES; j++) begin
            hreg_ff[j] <= hreg_ff[j-1];
         end
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_pixel = rsp_pixel_ff;
   assign out_last  = rsp_last_ff;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the square window min/max filter core.
// Depends on swmm_pkg, swmm_req_if, swmm_rsp_if and the core RTL.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 2 * swmm_pkg::MAX_RADIUS * swmm_pkg::MAX_WIDTH
                                + 2 * swmm_pkg::MAX_RADIUS + 1;
   localparam int IDLE_LIMIT  = 5000;
   localparam int RANDOM_WORDS = 400;

   typedef struct {
      logic [7:0] pix;
      logic       last;
   } filtered_word_type;

   // Window filter predictor and queue of expected filtered words
   class window_scoreboard;
      logic [11:0]       width_reg, height_reg;
      logic [2:0]        radius_reg;
      logic              mode_reg;
      logic [7:0]        line_store[STORE_DEPTH];
      int unsigned       in_col, in_row;
      filtered_word_type expected_q[$];
      int                errors, checked;

      function new();
         width_reg  = 12'd640;
         height_reg = 12'd480;
         radius_reg = 3'd2;
         mode_reg   = 1'b0;
         foreach (line_store[i]) line_store[i] = 8'd0;
         in_col = 0;
         in_row = 0;
         errors = 0;
         checked = 0;
      endfunction

      function int unsigned eff_w();
         if (width_reg == 0) return 1;
         if (width_reg > swmm_pkg::MAX_WIDTH) return swmm_pkg::MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned eff_h();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function int unsigned eff_r();
         return (radius_reg > swmm_pkg::MAX_RADIUS) ? swmm_pkg::MAX_RADIUS : radius_reg;
      endfunction

      function void set_reg(swmm_pkg::csr_index_type idx, logic [11:0] val);
         case (idx)
            swmm_pkg::CSR_FRAME_WIDTH:   width_reg  = val;
            swmm_pkg::CSR_FRAME_HEIGHT:  height_reg = val;
            swmm_pkg::CSR_WINDOW_RADIUS: radius_reg = val[2:0];
            swmm_pkg::CSR_FILTER_MODE:   mode_reg   = val[0];
            default: ;
         endcase
      endfunction

      // Accepted input word: update position and store, queue the filtered word
      function void note_input(logic [7:0] pix, logic fill);
         int unsigned w, h, r, m, d, n, last_idx, oy, ox, y0, y1, x0, x1;
         logic [7:0]  acc, v;
         logic        fl;
         w = eff_w();
         h = eff_h();
         r = eff_r();
         if (in_row < h && fill) return;   // fill inside a frame is dropped
         m = in_row * w + in_col;
         if (in_row < h) line_store[m % STORE_DEPTH] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         d = r * w + r;
         if (m < d) return;
         n = m - d;
         last_idx = w * h - 1;
         fl = 1'b0;
         if (n >= last_idx) begin
            n = last_idx;
            fl = 1'b1;
         end
         oy = n / w;
         ox = n % w;
         y0 = (oy >= r) ? oy - r : 0;
         y1 = (oy + r < h) ? oy + r : h - 1;
         x0 = (ox >= r) ? ox - r : 0;
         x1 = (ox + r < w) ? ox + r : w - 1;
         acc = mode_reg ? 8'd0 : 8'd255;
         for (int unsigned y = y0; y <= y1; y++) begin
            for (int unsigned x = x0; x <= x1; x++) begin
               v = line_store[(y * w + x) % STORE_DEPTH];
               if (mode_reg ? (v > acc) : (v < acc)) acc = v;
            end
         end
         if (fl) begin
            in_row = 0;
            in_col = 0;
         end
         expected_q.push_back('{pix: acc, last: fl});
      endfunction

      function void report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endfunction

      function void check_result(logic [7:0] pix, logic last);
         filtered_word_type exp_word;
         checked++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected word pixel_out=%0d frame_last=%0b", pix, last));
            return;
         end
         exp_word = expected_q.pop_front();
         if (pix !== exp_word.pix)
            report($sformatf("word %0d pixel_out=%0d expected %0d",
                             checked, pix, exp_word.pix));
         if (last !== exp_word.last)
            report($sformatf("word %0d frame_last=%0b expected %0b",
                             checked, last, exp_word.last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [swmm_pkg::CSR_IDX_W-1:0]  csr_index = swmm_pkg::CSR_FRAME_WIDTH;
   logic [swmm_pkg::DIM_W-1:0]      csr_write_data = '0;

   swmm_req_if req_bus ();
   swmm_rsp_if rsp_bus ();

   square_window_min_max_filter_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   window_scoreboard sb = new();
   int  words_sent   = 0;
   int  frames_done  = 0;
   int  idle_cycles  = 0;
   bit  sender_steady = 0;

   always #10 clock = ~clock;

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.pixel_in = '0;
      req_bus.is_fill  = 1'b0;
      rsp_bus.ready    = 1'b0;
   end

   // Random gap length: mostly short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one word and wait for it to be taken
   task automatic send_word(logic [7:0] pix, logic fill);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid    = 1'b1;
      req_bus.pixel_in = pix;
      req_bus.is_fill  = fill;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_input(pix, fill);
      words_sent++;
   endtask

   // Wait for every expected word, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(swmm_pkg::csr_index_type idx, logic [11:0] val);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic configure(logic [11:0] w, logic [11:0] h, logic [2:0] r, logic mode);
      drain();
      write_reg(swmm_pkg::CSR_FRAME_WIDTH, w);
      write_reg(swmm_pkg::CSR_FRAME_HEIGHT, h);
      write_reg(swmm_pkg::CSR_WINDOW_RADIUS, {9'd0, r});
      write_reg(swmm_pkg::CSR_FILTER_MODE, {11'd0, mode});
   endtask

   // One frame of pixels with stray fills, then the flush words
   task automatic run_frame(int fill_pct);
      int unsigned total, flush_len;
      logic [7:0]  pix;
      int          roll;
      total     = sb.eff_w() * sb.eff_h();
      flush_len = sb.eff_r() * sb.eff_w() + sb.eff_r();
      sender_steady = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(0, 99) < fill_pct) send_word(8'($urandom), 1'b1);
         roll = $urandom_range(0, 9);
         pix = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom);
         send_word(pix, 1'b0);
      end
      // a pixel word during flush counts as a fill
      for (int unsigned i = 0; i < flush_len; i++)
         send_word(8'($urandom), ($urandom_range(0, 99) < 85));
      frames_done++;
   endtask

   // Result side: random stalls and one long hold-off
   initial begin
      int  stall_left, hold_left;
      bit  held, steady;
      stall_left = 0;
      hold_left  = 0;
      held       = 0;
      steady     = 0;
      forever begin
         @(negedge clock);
         if (!held && sb.checked >= 60) begin
            held = 1;
            hold_left = 300;
         end
         if ($urandom_range(0, 199) == 0) steady = ~steady;
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!steady) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.pixel_out, rsp_bus.frame_last);
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: single pixel, both extremes, no window
      configure(12'd1, 12'd1, 3'd0, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd255, 1'b0);
      // small frame, maximum, stray fill and pixel during flush
      configure(12'd3, 12'd2, 3'd1, 1'b1);
      send_word(8'd255, 1'b0);
      send_word(8'd7, 1'b1);
      send_word(8'd0, 1'b0);
      send_word(8'd128, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd255, 1'b0);
      send_word(8'd1, 1'b0);
      send_word(8'd9, 1'b0);
      repeat (3) send_word(8'd200, 1'b1);
      // zero sizes act as one, largest radius
      configure(12'd0, 12'd0, 3'd7, 1'b0);
      run_frame(0);

      // Random settings, one or two frames each; radius may exceed the width
      while (words_sent < RANDOM_WORDS) begin
         configure(12'($urandom_range(1, 12)), 12'($urandom_range(1, 8)),
                   3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         repeat ($urandom_range(1, 2)) run_frame(5);
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d expected words never arrived", sb.expected_q.size()));
      $display("covered %0d input words over %0d frames, %0d filtered words checked",
               words_sent, frames_done, sb.checked);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
